// ===== rtl/rmt_pkg.sv =====
// rect merge table: shared types, constants and helper functions
// no dependencies; imported by every module of the block
package rmt_pkg;

    localparam int MAX_RECTS_DEF = 32;
    localparam int COORD_W       = 16;
    localparam int RD_IDX_W      = 5;
    localparam int CNT_OUT_W     = 6;
    localparam int MARGIN_W      = 8;
    localparam logic [MARGIN_W-1:0] MARGIN_RST = 8'd16;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // stored entry, left in the low bits
    typedef struct packed {
        t_coord bottom;
        t_coord right;
        t_coord top;
        t_coord left;
    } t_rect;

    typedef struct packed {
        logic [1:0]          req_type;
        t_coord              new_left;
        t_coord              new_top;
        t_coord              new_right;
        t_coord              new_bottom;
        logic [RD_IDX_W-1:0] read_index;
    } t_in_item;

    typedef struct packed {
        t_coord               entry_left;
        t_coord               entry_top;
        t_coord               entry_right;
        t_coord               entry_bottom;
        logic                 entry_valid;
        logic [CNT_OUT_W-1:0] rect_count;
        logic [CNT_OUT_W-1:0] merges_done;
        logic                 overflow;
    } t_out_item;

    // per-cell control from the sequencer
    typedef struct packed {
        logic hit_qual;   // latch the merge test result
        logic hit_index;  // latch the read address match
        logic shift;      // take the neighbor's entry
        logic load;       // take the new rectangle
    } t_cell_ctl;

    function automatic t_coord smax(input t_coord a, input t_coord b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_coord smin(input t_coord a, input t_coord b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_rect rect_union(input t_rect a, input t_rect b);
        t_rect u;
        u.left   = smin(a.left, b.left);
        u.top    = smin(a.top, b.top);
        u.right  = smax(a.right, b.right);
        u.bottom = smax(a.bottom, b.bottom);
        return u;
    endfunction

endpackage

// ===== rtl/rmt_cell.sv =====
// rect merge table: one table slot with its own merge test and read match
// depends on rmt_pkg
module rmt_cell
    import rmt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [CW-1:0]       i_count,
    input  logic [RD_IDX_W-1:0] i_read_index,
    input  t_rect               i_probe,
    input  t_rect               i_rect,
    input  t_rect               i_next,
    output t_rect               o_entry,
    output logic                o_hit
);

    t_rect r_entry;
    logic  r_hit;

    t_coord            il, ir, it, ib;
    logic signed [16:0] iw, ih, nh, eh;
    logic signed [17:0] ih2, nh2, eh2;
    logic              in_range, qual, idx_match, n_hit;

    always_comb begin
        il  = smax(r_entry.left, i_probe.left);
        ir  = smin(r_entry.right, i_probe.right);
        it  = smax(r_entry.top, i_probe.top);
        ib  = smin(r_entry.bottom, i_probe.bottom);
        iw  = {ir[15], ir} - {il[15], il};
        ih  = {ib[15], ib} - {it[15], it};
        nh  = {i_rect.bottom[15], i_rect.bottom} - {i_rect.top[15], i_rect.top};
        eh  = {r_entry.bottom[15], r_entry.bottom} - {r_entry.top[15], r_entry.top};
        ih2 = {ih, 1'b0};
        nh2 = {nh[16], nh};
        eh2 = {eh[16], eh};
        qual = (iw > 17'sd0) && (ih > 17'sd0) && ((ih2 > nh2) || (ih2 > eh2));
        in_range  = CW'(IDX) < i_count;
        idx_match = int'(i_read_index) == IDX;
        n_hit = in_range && ((i_ctl.hit_qual && qual) || (i_ctl.hit_index && idx_match));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_rect;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

// ===== rtl/rect_merge_table_unit.sv =====
// rect merge table: top level, sequencer, output register and a row of cells
// depends on rmt_pkg and rmt_cell
// one request in work at a time; the next is taken the cycle after its result is registered
// each merge pass is a scan state of per-cell tests followed by an eval state of first-hit select and shift
// synchronous active-low reset empties the table and sets the margin to 16; entries keep data
module rect_merge_table_unit
    import rmt_pkg::*;
#(
    parameter int MAX_RECTS = MAX_RECTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_data,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_data,
    // margin register write
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [MARGIN_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_RECTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,    // cells latch their hit bits
        S_EVAL,    // first hit selected, merge or append or read
        S_DONE     // hand result to the output register
    } t_state;

    t_state                r_state;
    t_req                  r_req;
    t_rect                 r_n;
    logic [RD_IDX_W-1:0]   r_rd_idx;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_merges;
    logic                  r_ovf;
    t_rect                 r_ent;
    logic                  r_ent_valid;
    logic [MARGIN_W-1:0]   r_margin;
    logic                  r_out_valid;
    t_out_item             r_out;

    t_cell_ctl             w_ctl   [MAX_RECTS];
    t_rect                 w_entry [MAX_RECTS];
    t_rect                 w_next  [MAX_RECTS];
    logic [MAX_RECTS-1:0]  w_hits;
    logic [MAX_RECTS-1:0]  w_less1, w_first, w_from;
    t_rect                 w_sel;
    t_rect                 n_union;
    t_rect                 w_probe;
    logic signed [16:0]    w_pl;
    logic                  w_any, w_accept, w_out_free, w_merge, w_append;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;

    // probe: left edge pulled left by the margin, floored at zero
    always_comb begin
        w_pl    = {r_n.left[15], r_n.left} - {9'b0, r_margin};
        w_probe = r_n;
        w_probe.left = w_pl[16] ? '0 : w_pl[15:0];
    end

    // first hit in table order, and every slot from it onward
    always_comb begin
        w_less1 = w_hits - MAX_RECTS'(1);
        w_first = w_hits & ~w_less1;
        w_from  = ~(w_hits ^ w_less1) | w_first;
        w_any   = |w_hits;
        w_sel   = '0;
        for (int i = 0; i < MAX_RECTS; i++) begin
            w_sel = w_sel | (w_first[i] ? w_entry[i] : t_rect'('0));
        end
        n_union = rect_union(w_sel, r_n);
    end

    assign w_merge  = (r_state == S_EVAL) && (r_req == REQ_ADD) && w_any;
    assign w_append = (r_state == S_EVAL) && (r_req == REQ_ADD) && !w_any
                      && (r_count < CW'(MAX_RECTS));

    // row of cells, each handing its entry to the one before it
    for (genvar g = 0; g < MAX_RECTS; g++) begin : g_cell
        if (g == MAX_RECTS - 1) begin : g_last
            assign w_next[g] = '0;
        end else begin : g_mid
            assign w_next[g] = w_entry[g + 1];
        end

        always_comb begin
            w_ctl[g].hit_qual  = (r_state == S_SCAN) && (r_req == REQ_ADD);
            w_ctl[g].hit_index = (r_state == S_SCAN) && (r_req == REQ_READ);
            w_ctl[g].shift     = w_merge && w_from[g];
            w_ctl[g].load      = w_append && (r_count == CW'(g));
        end

        rmt_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[g]),
            .i_count      (r_count),
            .i_read_index (r_rd_idx),
            .i_probe      (w_probe),
            .i_rect       (r_n),
            .i_next       (w_next[g]),
            .o_entry      (w_entry[g]),
            .o_hit        (w_hits[g])
        );
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_margin    <= MARGIN_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_margin <= i_cfg_data;
            end
            // while done, the load below decides valid
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req        <= t_req'(i_in_data.req_type);
                        r_n.left     <= i_in_data.new_left;
                        r_n.top      <= i_in_data.new_top;
                        r_n.right    <= i_in_data.new_right;
                        r_n.bottom   <= i_in_data.new_bottom;
                        r_rd_idx     <= i_in_data.read_index;
                        r_merges     <= '0;
                        r_ovf        <= 1'b0;
                        r_ent        <= '0;
                        r_ent_valid  <= 1'b0;
                        unique case (t_req'(i_in_data.req_type))
                            REQ_ADD, REQ_READ: r_state <= S_SCAN;
                            REQ_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                            REQ_NONE:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_req == REQ_READ) begin
                        // at most one cell matches the read address
                        r_ent       <= w_sel;
                        r_ent_valid <= w_any;
                        r_state     <= S_DONE;
                    end else if (w_any) begin
                        // absorb the first hit and test the union again
                        r_n      <= n_union;
                        r_count  <= r_count - CW'(1);
                        r_merges <= r_merges + CW'(1);
                        r_state  <= S_SCAN;
                    end else begin
                        if (w_append) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out.entry_left   <= r_ent.left;
            r_out.entry_top    <= r_ent.top;
            r_out.entry_right  <= r_ent.right;
            r_out.entry_bottom <= r_ent.bottom;
            r_out.entry_valid  <= r_ent_valid;
            r_out.rect_count   <= CNT_OUT_W'(r_count);
            r_out.merges_done  <= CNT_OUT_W'(r_merges);
            r_out.overflow     <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/rmt_checker.sv =====
// rect merge table: port-level checks, bound to the top level
// depends on rmt_pkg
module rmt_checker
    import rmt_pkg::*;
#(
    parameter int MAX_RECTS = MAX_RECTS_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input t_out_item           o_out_data
);

    // a dropped add only happens on a full table with nothing merged
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.overflow) |->
            (o_out_data.merges_done == '0) && !o_out_data.entry_valid
            && (o_out_data.rect_count == CNT_OUT_W'(MAX_RECTS)))
        else $error("overflow reported with merges or non-full table");

    // a read result never carries add status
    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.entry_valid) |->
            (o_out_data.merges_done == '0) && !o_out_data.overflow)
        else $error("read result carries add status");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item taken while one is in work");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind rect_merge_table_unit rmt_checker #(.MAX_RECTS(MAX_RECTS)) u_rmt_checker (.*);
